FILE: hw/rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg: shared types and constants
// Frame geometry, byte and word types, and the result bundle passed from the
// frame core to the top level.
// ----------------------------------------------------------------------------
package msr_pkg;

	// frame geometry
	localparam int FRAME_SLOTS = 10;
	localparam int POS_W       = 4;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;

	// fixed slot roles
	localparam logic [POS_W-1:0] SLOT_OPEN  = POS_W'(0);
	localparam logic [POS_W-1:0] SLOT_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] SLOT_CLOSE = POS_W'(FRAME_SLOTS - 1);
	localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(FRAME_SLOTS);

	typedef logic [BYTE_W-1:0]        octet_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]         pos_t;

	// result of processing one item
	typedef struct packed {
		logic  hit;
		word_t breath;
		word_t heart;
	} result_t;

endpackage

FILE: hw/rtl/marker_framed_sample_receiver.sv
// ----------------------------------------------------------------------------
// marker_framed_sample_receiver: marker-framed byte receiver
// A closing byte passes the input register and frame update; its result is then held in the result register.
// Throughput: one byte per cycle while the result side takes results.
// The input register, frame update and result register form the path.
// Reset clears the frame store, position, marker and all valid flags.
// ----------------------------------------------------------------------------
module marker_framed_sample_receiver (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  msr_pkg::octet_t rx_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output msr_pkg::word_t  breath_word,
	output msr_pkg::word_t  heart_word,
	input  logic            cfg_we,
	input  msr_pkg::octet_t cfg_wdata
);
	import msr_pkg::*;

	logic    valid_s1;
	octet_t  byte_s1;
	octet_t  marker_q;
	logic    out_valid_q;
	word_t   breath_q;
	word_t   heart_q;
	logic    advance;
	result_t res;

	// stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '0;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	msr_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.rx_byte (byte_s1),
		.marker  (marker_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			breath_q <= res.breath;
			heart_q  <= res.heart;
		end
	end

	assign out_valid   = out_valid_q;
	assign breath_word = breath_q;
	assign heart_word  = heart_q;

`ifndef SYNTH
	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("pending result overwritten");

	// a stalled stage 1 item keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 item lost while stalled");

	// a processed closing byte always raises the result flag
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.hit |=> out_valid_q)
		else $error("closed frame gave no result");
`endif

endmodule

FILE: hw/rtl/msr_frame_core.sv
// ----------------------------------------------------------------------------
// msr_frame_core: frame store and write position
// Stores each byte at the write position, tracks frame open and close
// markers, and flags a closed frame together with its two packed words.
// ----------------------------------------------------------------------------
module msr_frame_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  msr_pkg::octet_t  rx_byte,
	input  msr_pkg::octet_t  marker,
	output msr_pkg::result_t res
);
	import msr_pkg::*;

	octet_t store_q [FRAME_SLOTS];
	pos_t   pos_q;

	octet_t store_new [FRAME_SLOTS];
	pos_t   wr_pos;
	pos_t   pos_inc;
	pos_t   pos_next;

	// write slot, with overrun wrap to slot 0
	assign wr_pos  = (pos_q >= POS_LIMIT) ? SLOT_OPEN : pos_q;
	assign pos_inc = wr_pos + POS_W'(1);

	// store contents after this byte is written
	always_comb begin
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			store_new[i] = (wr_pos == POS_W'(i)) ? rx_byte : store_q[i];
		end
	end

	// position after open and in-frame marker checks
	always_comb begin
		pos_next = pos_inc;
		if (store_new[SLOT_OPEN] != marker) begin
			pos_next = SLOT_OPEN;
		end else if (store_new[SLOT_FIRST] == marker) begin
			pos_next = SLOT_FIRST;
		end
		// a marker written past slot 1 drops the frame
		if (pos_next > SLOT_FIRST && rx_byte == marker) begin
			pos_next = SLOT_OPEN;
		end
	end

	// closed frame and its words
	assign res.hit    = (store_new[SLOT_CLOSE] == marker);
	assign res.breath = {store_new[1], store_new[2], store_new[3], store_new[4]};
	assign res.heart  = {store_new[5], store_new[6], store_new[7], store_new[8]};

	// state update, closing slot cleared on a closed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= SLOT_OPEN;
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				store_q[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < FRAME_SLOTS; i++) begin
				if (res.hit && POS_W'(i) == SLOT_CLOSE) begin
					store_q[i] <= '0;
				end else begin
					store_q[i] <= store_new[i];
				end
			end
			pos_q <= res.hit ? SLOT_OPEN : pos_next;
		end
	end

`ifndef SYNTH
	// position never runs beyond one past the last slot
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("write position out of range");

	// a closed frame restarts at slot 0 with the closing slot cleared
	a_close_reset: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.hit |=> pos_q == SLOT_OPEN && store_q[SLOT_CLOSE] == '0)
		else $error("frame close did not reset position and slot");

	// idle cycles leave the position alone
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(pos_q))
		else $error("position changed without an item");
`endif

endmodule
